FILE: rtl/u8v_pkg.sv
// Package for the UTF-8 stream validator: decoder state type, byte class
// masks and code point limits. Depends on nothing.
`default_nettype none

package u8v_pkg;

	localparam int CpWidth = 21;

	typedef logic [CpWidth-1:0] u8v_cp_t;

	typedef struct packed {
		logic [1:0] pending;   // continuation bytes still expected
		logic [1:0] seq_len;   // continuation count of current sequence
		u8v_cp_t    cp;        // code point being assembled
		logic       err;       // error found in current string
	} u8v_state_t;

	localparam logic [1:0] ContTag       = 2'b10;
	localparam logic [7:0] Lead2Mask     = 8'h1f;
	localparam logic [7:0] Lead3Mask     = 8'h0f;
	localparam logic [7:0] Lead4Mask     = 8'h07;
	localparam logic [1:0] SeqLen3       = 2'd2;
	localparam logic [1:0] SeqLen4       = 2'd3;
	localparam u8v_cp_t    Min3Byte      = 21'h000800;
	localparam u8v_cp_t    Min4Byte      = 21'h010000;
	localparam u8v_cp_t    MaxCodePoint  = 21'h10ffff;
	localparam u8v_cp_t    SurrogateLo   = 21'h00d800;
	localparam u8v_cp_t    SurrogateHi   = 21'h00dfff;

endpackage

`default_nettype wire

FILE: rtl/u8v_stream_if.sv
// Valid/ready channel interfaces for the UTF-8 stream validator: the byte
// channel and the verdict channel. Depends on nothing.
`default_nettype none

interface u8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface u8v_verdict_if;
	logic valid;
	logic ready;
	logic valid_res;

	modport source (output valid, output valid_res, input ready);
	modport sink   (input valid, input valid_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/u8v_step.sv
// Next-state logic of the UTF-8 decoder for one byte: lead classification,
// continuation assembly and end-of-sequence range checks. Uses u8v_pkg.
`default_nettype none

module u8v_step (
	input  wire u8v_pkg::u8v_state_t cur,
	input  wire logic [7:0]          data_byte,
	output u8v_pkg::u8v_state_t      nxt
);

	u8v_pkg::u8v_cp_t cp_cat;
	logic [1:0]       pend_dec;
	logic             range_bad;

	assign cp_cat   = {cur.cp[u8v_pkg::CpWidth-7:0], data_byte[5:0]};
	assign pend_dec = cur.pending - 2'd1;

	always_comb begin
		range_bad = ((cur.seq_len == u8v_pkg::SeqLen3) && (cp_cat < u8v_pkg::Min3Byte)) ||
			((cur.seq_len == u8v_pkg::SeqLen4) && (cp_cat < u8v_pkg::Min4Byte)) ||
			(cp_cat > u8v_pkg::MaxCodePoint) ||
			((cp_cat >= u8v_pkg::SurrogateLo) && (cp_cat <= u8v_pkg::SurrogateHi));
	end

	always_comb begin
		nxt = cur;
		if (cur.err) begin
			nxt = cur;
		end else if (cur.pending == 2'd0) begin
			case (data_byte) inside
				8'h00: begin
					nxt.err = 1'b1;
				end
				[8'h01:8'h7f]: begin
					nxt = cur;
				end
				[8'hc2:8'hdf]: begin
					nxt.cp      = u8v_pkg::u8v_cp_t'(data_byte & u8v_pkg::Lead2Mask);
					nxt.pending = 2'd1;
					nxt.seq_len = 2'd1;
				end
				[8'he0:8'hef]: begin
					nxt.cp      = u8v_pkg::u8v_cp_t'(data_byte & u8v_pkg::Lead3Mask);
					nxt.pending = 2'd2;
					nxt.seq_len = 2'd2;
				end
				[8'hf0:8'hf7]: begin
					nxt.cp      = u8v_pkg::u8v_cp_t'(data_byte & u8v_pkg::Lead4Mask);
					nxt.pending = 2'd3;
					nxt.seq_len = 2'd3;
				end
				// stray continuation, C0/C1 and F8 upwards
				default: begin
					nxt.err = 1'b1;
				end
			endcase
		end else if (data_byte[7:6] != u8v_pkg::ContTag) begin
			nxt.err = 1'b1;
		end else if (pend_dec != 2'd0) begin
			nxt.cp      = cp_cat;
			nxt.pending = pend_dec;
		end else begin
			// sequence complete: check form and range, then drop the code point
			nxt.pending = 2'd0;
			nxt.seq_len = 2'd0;
			nxt.cp      = '0;
			nxt.err     = range_bad;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/utf8_stream_validator.sv
// UTF-8 stream validator: one byte per cycle unless the skid register is
// full, one verdict per string on its last byte. The verdict is registered,
// into the result register or, if that still waits, the skid register; this
// two-entry output stage lets bytes flow while one verdict waits. Reset:
// asynchronous, active low; clears decoder state and the output stage.
// Uses u8v_pkg, u8v_byte_if, u8v_verdict_if and u8v_step.
`default_nettype none

module utf8_stream_validator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	u8v_byte_if.sink        text,
	u8v_verdict_if.source   verdict
);

	u8v_pkg::u8v_state_t state_q;
	u8v_pkg::u8v_state_t state_nxt;
	logic                out_valid_q;
	logic                out_res_q;
	logic                skid_valid_q;
	logic                skid_res_q;
	logic                in_fire;
	logic                out_fire;
	logic                give;
	logic                res_new;

	u8v_step u_step (
		.cur       (state_q),
		.data_byte (text.data_byte),
		.nxt       (state_nxt)
	);

	assign text.ready      = !skid_valid_q;
	assign in_fire         = text.valid && text.ready;
	assign out_fire        = out_valid_q && verdict.ready;
	assign give            = in_fire && text.last;
	assign res_new         = !state_nxt.err && (state_nxt.pending == 2'd0);
	assign verdict.valid     = out_valid_q;
	assign verdict.valid_res = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_fire) begin
			state_q <= text.last ? '0 : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (give) begin
			if (out_valid_q && !verdict.ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_res_q <= skid_res_q;
			end
		end else if (give) begin
			if (out_valid_q && !verdict.ready) begin
				skid_res_q <= res_new;
			end else begin
				out_res_q <= res_new;
			end
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a verdict while the result register is empty");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.ready && text.last) |=> (state_q == '0))
		else $error("decoder state not cleared after the last byte");

	a_verdict_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.ready && text.last) |=> out_valid_q)
		else $error("no verdict after an accepted last byte");

	a_pending_within_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.pending != 2'd0) |-> (state_q.seq_len != 2'd0 &&
			state_q.pending <= state_q.seq_len))
		else $error("pending count outside the current sequence");

endmodule

`default_nettype wire

FILE: test/utf8_stream_validator_test.sv
`timescale 1ns / 1ps
// Testbench for utf8_stream_validator: drives byte strings and checks each verdict
// against an in-bench UTF-8 decoder. Depends on u8v_pkg, u8v_stream_if.sv and the RTL.

module utf8_stream_validator_test;

	typedef struct packed {
		logic [7:0] octet;
		logic       ends;
	} text_beat_t;

	logic clk;
	logic arst_n;

	u8v_byte_if    text_ch ();
	u8v_verdict_if verdict_ch ();

	utf8_stream_validator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.verdict(verdict_ch)
	);

	text_beat_t  bytes_to_send[$];
	logic        verdicts_due[$];
	logic [7:0]  draft[$];
	text_beat_t  beat;

	// decoder state of the bench
	logic [1:0]        cont_left = '0;
	logic [1:0]        seq_cont = '0;
	u8v_pkg::u8v_cp_t  cp_acc = '0;
	logic              string_bad = 1'b0;

	int unsigned bytes_in = 0;
	int unsigned mismatches = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	logic        calm;

	assign calm = ((bytes_in / 128) % 4) == 2;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("utf8_stream_validator_test: errors");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic void judge_byte(input logic [7:0] b, input logic is_last,
			output logic has_res, output logic res_ok);
		if (!string_bad) begin
			if (cont_left == 2'd0) begin
				if (b == 8'h00) begin
					string_bad = 1'b1;
				end else if (b[7]) begin
					if (b[7:5] == 3'b110) begin
						if (b[4:0] < 5'd2) begin
							string_bad = 1'b1;
						end else begin
							cp_acc = u8v_pkg::u8v_cp_t'(b & u8v_pkg::Lead2Mask);
							cont_left = 2'd1;
							seq_cont = 2'd1;
						end
					end else if (b[7:4] == 4'b1110) begin
						cp_acc = u8v_pkg::u8v_cp_t'(b & u8v_pkg::Lead3Mask);
						cont_left = 2'd2;
						seq_cont = u8v_pkg::SeqLen3;
					end else if (b[7:3] == 5'b11110) begin
						cp_acc = u8v_pkg::u8v_cp_t'(b & u8v_pkg::Lead4Mask);
						cont_left = 2'd3;
						seq_cont = u8v_pkg::SeqLen4;
					end else begin
						// stray continuation or lead of F8 and up
						string_bad = 1'b1;
					end
				end
			end else if (b[7:6] != u8v_pkg::ContTag) begin
				string_bad = 1'b1;
			end else begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					if ((seq_cont == u8v_pkg::SeqLen3 && cp_acc < u8v_pkg::Min3Byte) ||
							(seq_cont == u8v_pkg::SeqLen4 && cp_acc < u8v_pkg::Min4Byte) ||
							cp_acc > u8v_pkg::MaxCodePoint ||
							(cp_acc >= u8v_pkg::SurrogateLo &&
							cp_acc <= u8v_pkg::SurrogateHi))
						string_bad = 1'b1;
					seq_cont = 2'd0;
					cp_acc = '0;
				end
			end
		end
		has_res = is_last;
		res_ok = !string_bad && cont_left == 2'd0;
		if (is_last) begin
			cont_left = 2'd0;
			seq_cont = 2'd0;
			cp_acc = '0;
			string_bad = 1'b0;
		end
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		draft = {draft, b};
	endfunction

	task automatic commit_string();
		text_beat_t t;
		for (int i = 0; i < draft.size(); i++) begin
			t.octet = draft[i];
			t.ends = (i == draft.size() - 1);
			bytes_to_send = {bytes_to_send, t};
		end
		draft.delete();
	endtask

	task automatic add_char(input u8v_pkg::u8v_cp_t v, input int n);
		case (n)
			1: put_byte({1'b0, v[6:0]});
			2: begin
				put_byte({3'b110, v[10:6]});
				put_byte({u8v_pkg::ContTag, v[5:0]});
			end
			3: begin
				put_byte({4'b1110, v[15:12]});
				put_byte({u8v_pkg::ContTag, v[11:6]});
				put_byte({u8v_pkg::ContTag, v[5:0]});
			end
			default: begin
				put_byte({5'b11110, v[20:18]});
				put_byte({u8v_pkg::ContTag, v[17:12]});
				put_byte({u8v_pkg::ContTag, v[11:6]});
				put_byte({u8v_pkg::ContTag, v[5:0]});
			end
		endcase
	endtask

	task automatic make_random_string();
		int unsigned kind;
		int unsigned r;
		u8v_pkg::u8v_cp_t v;
		if ($urandom_range(0, 15) == 0) begin
			// pure noise
			repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				kind = $urandom_range(0, 19);
				if (kind < 8) begin
					add_char(u8v_pkg::u8v_cp_t'($urandom_range(1, 127)), 1);
				end else if (kind < 11) begin
					add_char(u8v_pkg::u8v_cp_t'($urandom_range(16'h80, 16'h7ff)), 2);
				end else if (kind < 14) begin
					add_char(u8v_pkg::u8v_cp_t'($urandom_range(16'h800, 16'hffff)), 3);
				end else if (kind < 16) begin
					add_char(u8v_pkg::u8v_cp_t'($urandom_range(21'h10000, 21'h10ffff)), 4);
				end else if (kind < 18) begin
					case ($urandom_range(0, 12))
						0: add_char(21'h7f, 1);
						1: add_char(21'h80, 2);
						2: add_char(21'h7ff, 2);
						3: add_char(21'h800, 3);
						4: add_char(21'hd7ff, 3);
						5: add_char(21'hd800, 3);
						6: add_char(21'hdfff, 3);
						7: add_char(21'he000, 3);
						8: add_char(21'hffff, 3);
						9: add_char(21'h10000, 4);
						10: add_char(21'h10ffff, 4);
						11: add_char(21'h110000, 4);
						default: add_char(21'h1fffff, 4);
					endcase
				end else begin
					// length two to four, any value: overlong, out of range, C0/C1 leads
					add_char(u8v_pkg::u8v_cp_t'($urandom), $urandom_range(2, 4));
				end
			end
			r = $urandom_range(0, 15);
			if (r == 0)
				draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
			else if (r == 1 && draft.size() > 1)
				void'(draft.pop_back());
		end
		commit_string();
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
			text_ch.data_byte <= 8'h00;
			text_ch.last <= 1'b0;
			tx_gap = 0;
		end else if (!text_ch.valid || text_ch.ready) begin
			if (tx_gap != 0 || bytes_to_send.size() == 0) begin
				if (tx_gap != 0)
					tx_gap--;
				text_ch.valid <= 1'b0;
			end else begin
				beat = bytes_to_send.pop_front();
				text_ch.valid <= 1'b1;
				text_ch.data_byte <= beat.octet;
				text_ch.last <= beat.ends;
				tx_gap = pick_gap();
			end
		end
	end

	// long receiver hold-off, once, so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && bytes_in >= 600) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_ch.ready <= 1'b0;
			rx_gap = 0;
		end else if (rx_gap != 0) begin
			rx_gap--;
			verdict_ch.ready <= 1'b0;
		end else begin
			verdict_ch.ready <= (hold_left == 0);
			if (hold_left == 0)
				rx_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready) begin : take_byte
			logic has_res;
			logic res_ok;
			judge_byte(text_ch.data_byte, text_ch.last, has_res, res_ok);
			if (has_res)
				verdicts_due = {verdicts_due, res_ok};
			bytes_in <= bytes_in + 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin : take_verdict
			logic want;
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("verdict %0b with no string outstanding", verdict_ch.valid_res);
			end else begin
				want = verdicts_due.pop_front();
				if (verdict_ch.valid_res !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("verdict mismatch: expected %0b, got %0b",
							want, verdict_ch.valid_res);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.data_byte = 8'h00;
		text_ch.last = 1'b0;
		verdict_ch.ready = 1'b0;

		draft = {8'h00};                      commit_string(); // NUL
		draft = {8'h41, 8'h7f};               commit_string();
		draft = {8'h80};                      commit_string(); // stray continuation
		draft = {8'hc1, 8'hbf};               commit_string(); // C1 lead
		draft = {8'hf8};                      commit_string();
		draft = {8'hdf, 8'hbf};               commit_string();
		draft = {8'he0, 8'h9f, 8'hbf};        commit_string(); // overlong 3-byte
		draft = {8'hed, 8'ha0, 8'h80};        commit_string(); // surrogate
		draft = {8'hf4, 8'h90, 8'h80, 8'h80}; commit_string(); // above 10FFFF
		draft = {8'hf0, 8'h8f, 8'hbf, 8'hbf}; commit_string(); // overlong 4-byte
		draft = {8'he2, 8'h82};               commit_string(); // cut off
		draft = {8'hc2, 8'h00, 8'hff};        commit_string(); // bad continuation, rest dropped
		while (bytes_to_send.size() < 1930)
			make_random_string();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// sample on the falling edge so that the edge's updates have settled
		while (bytes_to_send.size() != 0 || text_ch.valid)
			@(negedge clk);
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("utf8_stream_validator_test: clean");
		else
			$display("utf8_stream_validator_test: errors");
		$finish;
	end

endmodule
